@@ hw/rtl/rpvg_pkg.sv @@
// package for the regular polygon vertex generator: sizes, codes, cordic angle table
package rpvg_pkg;

  localparam int MaxSides     = 64;
  localparam int CordicStages = 24;
  localparam int StageW       = $clog2(CordicStages + 1);
  localparam int SideW        = 7;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_REGULAR = 2'd1,
    ST_FEW_SIDES   = 2'd2
  } status_t;

  localparam logic signed [32:0] CordicX0 = 33'sd652032874;

  function automatic logic [31:0] atan_angle(input logic [4:0] k);
    logic [31:0] a;
    case (k)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10680862;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41721;
      5'd15: a = 32'd20860;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2607;
      5'd19: a = 32'd1303;
      5'd20: a = 32'd651;
      5'd21: a = 32'd325;
      5'd22: a = 32'd162;
      5'd23: a = 32'd81;
      5'd24: a = 32'd40;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd2;
      5'd29: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

@@ hw/rtl/regular_polygon_vertex_generator.sv @@
// regular polygon vertex generator: sequencer, shared cordic stage, scaling and output register
//
// in channel: one request per item (side count, regular flag, radius, centre).
// out channel: one item per vertex, index 0 at angle zero, last_vertex on the
// final one; a request with under three sides or not regular gives a single
// error item with status set and zero coordinates.
// side counts above 64 are taken as 64.
// the phase step 2^32/n comes from a restoring divider, one quotient bit
// per cycle. each vertex then takes a set-up step, the cordic iterations on
// the shared shift-add unit, scaling on one 32x34 multiplier (radius times
// cosine, x offset, radius times sine, y offset), loading of the output
// register and a wait until the item is taken. an error item is loaded
// straight from idle and likewise waits until it is taken.
// in_tready is high only while idle; one request is worked at a time.
// when the receiver stalls, the sequencer waits with the item held in the
// output register; nothing is lost.
// reset (rst_n low, synchronous) returns the sequencer to idle and empties
// the output register.
module regular_polygon_vertex_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // side_count[6:0], is_regular[7], circum_radius[38:8], center_x[70:39],
  // center_y[102:71], zero fill [103]
  input  logic [103:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // vertex_x[31:0], vertex_y[63:32], vertex_index[69:64], status[71:70]
  output logic [71:0] out_tdata,
  output logic        out_tlast
);
  import rpvg_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_PREP  = 7'b0000100,
    S_ROT   = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SideW-1:0]  n_r;
  logic [30:0]       rad_r;
  logic signed [31:0] cx_r, cy_r;
  logic [32:0]       rem_r;
  logic [31:0]       step_r, phase_r;
  logic [5:0]        div_cnt_r;
  logic [SideW-1:0]  vcnt_r;
  logic [StageW-1:0] stage_r;
  logic [1:0]        quad_r;
  logic signed [32:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic [1:0]        mcnt_r;
  logic signed [63:0] prod_r;
  logic signed [33:0] offx_r, offy_r;
  logic              ov_r;
  logic              ov_nxt;
  logic [71:0]       od_r;
  logic              ol_r;

  logic [SideW-1:0] in_n;
  assign in_n = in_tdata[6:0];

  // divider step
  logic [33:0] rem_sh;
  logic [33:0] rem_sub;
  assign rem_sh  = {rem_r, 1'b0};
  assign rem_sub = rem_sh - {27'd0, n_r};

  // cordic step
  logic signed [32:0] dx, dy;
  logic [31:0] ang;
  assign dx  = y_r >>> stage_r;
  assign dy  = x_r >>> stage_r;
  assign ang = atan_angle(5'(stage_r));

  // quadrant mapped cos/sin
  logic signed [33:0] cosv, sinv;
  always_comb begin
    case (quad_r)
      2'd0: begin cosv = 34'(x_r);  sinv = 34'(y_r);  end
      2'd1: begin cosv = -34'(y_r); sinv = 34'(x_r);  end
      2'd2: begin cosv = -34'(x_r); sinv = -34'(y_r); end
      default: begin cosv = 34'(y_r); sinv = -34'(x_r); end
    endcase
  end

  // shared multiplier: radius times one trig value
  logic signed [33:0] mop;
  assign mop = mcnt_r[1] ? sinv : cosv;
  logic signed [66:0] mprod;
  assign mprod = $signed({1'b0, rad_r}) * mop;

  logic signed [35:0] offr;
  assign offr = 36'((prod_r + 64'sd536870912) >>> 30);

  function automatic logic [31:0] sat(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'h7fffffff;
    if (v < -36'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  logic [32:0] ph_q;
  logic [31:0] ph_res;
  assign ph_q   = {1'b0, phase_r} + 33'h020000000;
  assign ph_res = phase_r - {ph_q[31:30], 30'd0};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        if (in_n < 7'd3 || !in_tdata[7]) state_nxt = S_WAIT;
        else state_nxt = S_DIV;
      end
      S_DIV:  if (div_cnt_r == 6'd32) state_nxt = S_PREP;
      S_PREP: state_nxt = S_ROT;
      S_ROT:  if (stage_r == StageW'(CordicStages - 1)) state_nxt = S_MUL;
      S_MUL:  if (mcnt_r == 2'd3) state_nxt = S_EMIT;
      S_EMIT: if (!ov_r || out_tready) state_nxt = S_WAIT;
      S_WAIT: if (!ov_r || out_tready) begin
        if (vcnt_r == n_r || n_r < 7'd3) state_nxt = S_IDLE;
        else state_nxt = S_PREP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    if (state_r == S_IDLE && in_tvalid && (in_n < 7'd3 || !in_tdata[7])) ov_nxt = 1'b1;
    if (state_r == S_EMIT && (!ov_r || out_tready)) ov_nxt = 1'b1;
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        rad_r     <= in_tdata[38:8];
        cx_r      <= in_tdata[70:39];
        cy_r      <= in_tdata[102:71];
        rem_r     <= 33'd1;
        div_cnt_r <= 6'd0;
        step_r    <= 32'd0;
        phase_r   <= 32'd0;
        vcnt_r    <= '0;
        if (in_tvalid && (in_n < 7'd3 || !in_tdata[7])) begin
          od_r <= {(in_n < 7'd3) ? ST_FEW_SIDES : ST_NOT_REGULAR, 70'd0};
          ol_r <= 1'b1;
          n_r  <= '0;
        end else begin
          n_r  <= (in_n > 7'(MaxSides)) ? 7'(MaxSides) : in_n;
        end
      end
      S_DIV: begin
        // dividend 2^32: leading one then 32 zero bits
        if (div_cnt_r != 6'd0) begin
          if (!rem_sub[33]) begin
            rem_r  <= rem_sub[32:0];
            step_r <= {step_r[30:0], 1'b1};
          end else begin
            rem_r  <= rem_sh[32:0];
            step_r <= {step_r[30:0], 1'b0};
          end
        end
        div_cnt_r <= div_cnt_r + 6'd1;
      end
      S_PREP: begin
        quad_r  <= ph_q[31:30];
        z_r     <= $signed(ph_res);
        x_r     <= CordicX0;
        y_r     <= '0;
        stage_r <= '0;
        mcnt_r  <= '0;
      end
      S_ROT: begin
        if (!z_r[31]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - $signed(ang);
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + $signed(ang);
        end
        stage_r <= stage_r + StageW'(1);
      end
      S_MUL: begin
        mcnt_r <= mcnt_r + 2'd1;
        if (mcnt_r == 2'd0 || mcnt_r == 2'd2) prod_r <= mprod[63:0];
        if (mcnt_r == 2'd1) offx_r <= offr[33:0];
        if (mcnt_r == 2'd3) offy_r <= offr[33:0];
      end
      S_EMIT: if (!ov_r || out_tready) begin
        od_r <= {ST_OK, vcnt_r[5:0],
                 sat(36'(cy_r) + 36'(offy_r)),
                 sat(36'(cx_r) + 36'(offx_r))};
        ol_r    <= (vcnt_r + 7'd1 == n_r);
        vcnt_r  <= vcnt_r + 7'd1;
        phase_r <= phase_r + step_r;
      end
      default: ;
    endcase
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_IDLE)) else $error("ready outside idle");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[71:70] != ST_OK) |-> out_tlast)
    else $error("error item not last");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("output changed under stall");
endmodule
